// ----- design/rrss_pkg.sv -----
// Shared types, constants and helpers for the round robin sleep scheduler.
package rrss_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DIST_W     = SLOT_W + 1;
    localparam int SLEEP_W    = 16;
    localparam int SLICE_W    = 8;
    localparam int MODE_W     = 3;
    localparam int TGT_W      = 4;
    localparam int OUT_SLOT_W = 4;

    localparam logic [SLICE_W-1:0] SLICE_LIMIT_RST = 8'd16;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [DIST_W-1:0] slot_dist_t;

    typedef enum logic [1:0] {
        SS_DEAD,
        SS_RUNNABLE,
        SS_RUNNING,
        SS_BLOCKED
    } slot_state_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK,
        MODE_SLEEP,
        MODE_BLOCK,
        MODE_EXIT,
        MODE_WAKE,
        MODE_FORK
    } mode_t;

    typedef enum logic [1:0] {
        PH_NONE,
        PH_SCAN,
        PH_COMMIT
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCAN,
        CS_DECIDE,
        CS_COMMIT,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SLEEP_W-1:0] sleep_ticks;
        logic [TGT_W-1:0]   target_slot;
    } in_t;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] running_slot;
        logic                  switched;
        logic [OUT_SLOT_W-1:0] new_slot;
        logic                  fork_failed;
    } out_t;

    typedef struct packed {
        slot_state_t        state;
        logic [SLEEP_W-1:0] sleep_left;
        logic               wait_forever;
        logic [SLICE_W-1:0] slice_used;
    } slot_rec_t;

    typedef struct packed {
        phase_t             phase;
        mode_t              mode;
        logic [SLEEP_W-1:0] sleep_ticks;
        logic               tick_en;
        logic               is_cur;
        logic               is_target;
        logic               is_sel;
        logic               is_fork_dst;
        logic               cont;
        logic               preempt;
        logic               resched;
        logic               fork_ok;
        logic [SLEEP_W-1:0] par_sleep;
        logic               par_wait;
        logic [SLICE_W-1:0] par_slice;
    } cell_cmd_t;

    localparam slot_rec_t REC_SLOT0 = '{
        state: SS_RUNNING, sleep_left: '0, wait_forever: 1'b0, slice_used: 8'd1};
    localparam slot_rec_t REC_DEAD = '{
        state: SS_DEAD, sleep_left: '0, wait_forever: 1'b0, slice_used: 8'd0};

    localparam cell_cmd_t CMD_IDLE = cell_cmd_t'('0);

    function automatic logic [OUT_SLOT_W-1:0] to_out_slot(input slot_idx_t idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[OUT_SLOT_W-1:0];
    endfunction

endpackage

// ----- design/round_robin_sleep_scheduler_unit.sv -----
// A transaction is taken only in the idle state, so a new one waits until the last result is loaded.
// The slot records sit in a ring that rotates one position per cycle, and each event
// needs a scan lap and a commit lap.
// Reset (aresetn low, synchronous): slot 0 running with slice count one, all other slots
// dead, running slot 0, slice limit 16; no result pending. No clearing pass is needed.
module round_robin_sleep_scheduler_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rrss_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rrss_pkg::out_t  m_data,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data
);

    rrss_pkg::slot_rec_t  rec     [rrss_pkg::SLOTS];
    rrss_pkg::slot_rec_t  upd_rec [rrss_pkg::SLOTS];
    rrss_pkg::cell_cmd_t  tail_cmd;

    rrss_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_rec    (rec[0]),
        .tail_upd    (upd_rec[rrss_pkg::SLOTS-1]),
        .tail_cmd    (tail_cmd)
    );

    // Each cell takes its neighbor's record; the head record wraps to the tail cell,
    // which applies the event update as it goes by.
    for (genvar k = 0; k < rrss_pkg::SLOTS; k++) begin : g_cell
        rrss_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .rst_rec ((k == 0) ? rrss_pkg::REC_SLOT0 : rrss_pkg::REC_DEAD),
            .nb_rec  (rec[(k + 1) % rrss_pkg::SLOTS]),
            .cmd     ((k == rrss_pkg::SLOTS - 1) ? tail_cmd : rrss_pkg::CMD_IDLE),
            .rec     (rec[k]),
            .upd_rec (upd_rec[k])
        );
    end

endmodule

// ----- design/rrss_cell.sv -----
// One slot record of the rotating ring, with the update applied as it passes.
module rrss_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rrss_pkg::slot_rec_t  rst_rec,
    input  rrss_pkg::slot_rec_t  nb_rec,
    input  rrss_pkg::cell_cmd_t  cmd,
    output rrss_pkg::slot_rec_t  rec,
    output rrss_pkg::slot_rec_t  upd_rec
);

    rrss_pkg::slot_rec_t             rec_reg;
    rrss_pkg::slot_rec_t             rec_next;
    logic [rrss_pkg::SLEEP_W-1:0]    dec;

    always_comb begin
        rec_next = nb_rec;
        dec      = nb_rec.sleep_left - 16'd1;
        case (cmd.phase)
            rrss_pkg::PH_SCAN: begin
                if (cmd.is_cur) begin
                    case (cmd.mode)
                        rrss_pkg::MODE_SLEEP: begin
                            if (cmd.sleep_ticks != '0) begin
                                rec_next.state        = rrss_pkg::SS_BLOCKED;
                                rec_next.sleep_left   = cmd.sleep_ticks;
                                rec_next.wait_forever = 1'b0;
                            end
                        end
                        rrss_pkg::MODE_BLOCK: begin
                            rec_next.state        = rrss_pkg::SS_BLOCKED;
                            rec_next.sleep_left   = '0;
                            rec_next.wait_forever = 1'b1;
                        end
                        rrss_pkg::MODE_EXIT: begin
                            rec_next.state = rrss_pkg::SS_DEAD;
                        end
                        default: begin
                        end
                    endcase
                end else if (cmd.tick_en && nb_rec.state == rrss_pkg::SS_BLOCKED &&
                             !nb_rec.wait_forever) begin
                    // A timed sleeper already at zero wraps and stays blocked.
                    rec_next.sleep_left = dec;
                    if (dec == '0) begin
                        rec_next.state = rrss_pkg::SS_RUNNABLE;
                    end
                end
                if (cmd.is_target && cmd.mode == rrss_pkg::MODE_WAKE &&
                    nb_rec.state == rrss_pkg::SS_BLOCKED) begin
                    rec_next.state        = rrss_pkg::SS_RUNNABLE;
                    rec_next.sleep_left   = '0;
                    rec_next.wait_forever = 1'b0;
                end
            end
            rrss_pkg::PH_COMMIT: begin
                if (cmd.is_cur && cmd.cont) begin
                    rec_next.slice_used = nb_rec.slice_used + 8'd1;
                end
                if (cmd.is_cur && cmd.preempt) begin
                    rec_next.state      = rrss_pkg::SS_RUNNABLE;
                    rec_next.slice_used = '0;
                end
                if (cmd.is_sel && cmd.resched) begin
                    rec_next.state      = rrss_pkg::SS_RUNNING;
                    rec_next.slice_used = 8'd1;
                end
                if (cmd.is_fork_dst && cmd.fork_ok) begin
                    rec_next.state        = rrss_pkg::SS_RUNNABLE;
                    rec_next.sleep_left   = cmd.par_sleep;
                    rec_next.wait_forever = cmd.par_wait;
                    rec_next.slice_used   = cmd.par_slice;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= rst_rec;
        end else begin
            rec_reg <= rec_next;
        end
    end

    assign rec     = rec_reg;
    assign upd_rec = rec_next;

endmodule

// ----- design/rrss_ctrl.sv -----
// Sequencer: handshakes, scan bookkeeping, scheduling decision and result register.
module rrss_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rrss_pkg::in_t        s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rrss_pkg::out_t       m_data,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  rrss_pkg::slot_rec_t  head_rec,
    input  rrss_pkg::slot_rec_t  tail_upd,
    output rrss_pkg::cell_cmd_t  tail_cmd
);

    rrss_pkg::ctrl_state_t          state_reg, state_next;
    rrss_pkg::slot_idx_t            head_reg, head_next;
    rrss_pkg::slot_idx_t            cnt_reg, cnt_next;
    rrss_pkg::slot_idx_t            cur_reg;
    rrss_pkg::in_t                  item_reg;
    logic                           tick_en_reg;
    logic [rrss_pkg::SLICE_W-1:0]   slice_limit_reg;
    rrss_pkg::slot_state_t          cur_st_reg;
    logic [rrss_pkg::SLICE_W-1:0]   cur_sl_reg;
    logic [rrss_pkg::SLEEP_W-1:0]   par_sleep_reg;
    logic                           par_wait_reg;
    logic [rrss_pkg::SLICE_W-1:0]   par_slice_reg;
    logic                           dead_found_reg;
    rrss_pkg::slot_idx_t            dead_idx_reg;
    logic                           run_found_reg;
    rrss_pkg::slot_idx_t            run_idx_reg;
    rrss_pkg::slot_dist_t           run_dist_reg;
    logic                           cont_reg, resched_reg, preempt_reg;
    logic                           fork_ok_reg, fork_fail_reg;
    rrss_pkg::slot_idx_t            sel_reg;
    logic                           m_valid_reg, m_valid_next;
    rrss_pkg::out_t                 m_data_reg, m_data_next;

    rrss_pkg::mode_t                mode_in;
    logic                           tick_in;
    logic                           cnt_last;
    logic                           is_cur;
    logic                           run_cand;
    rrss_pkg::slot_dist_t           ring_gap;
    logic                           cont_c, resched_c, preempt_c;
    rrss_pkg::slot_state_t          st_after;
    rrss_pkg::slot_idx_t            sel_c;
    logic                           out_load;
    rrss_pkg::phase_t               phase;

    assign mode_in  = rrss_pkg::mode_t'(s_data.mode);
    assign tick_in  = (mode_in == rrss_pkg::MODE_TICK) ||
                      (mode_in == rrss_pkg::MODE_SLEEP && s_data.sleep_ticks != '0) ||
                      (mode_in == rrss_pkg::MODE_BLOCK) ||
                      (mode_in == rrss_pkg::MODE_EXIT);
    assign cnt_last = (cnt_reg == rrss_pkg::slot_idx_t'(rrss_pkg::SLOTS - 1));
    assign head_next = (head_reg == rrss_pkg::slot_idx_t'(rrss_pkg::SLOTS - 1)) ?
                       '0 : head_reg + rrss_pkg::slot_idx_t'(1);
    assign is_cur   = (head_reg == cur_reg);

    // Round robin distance from the running slot: the slot right after it is nearest.
    always_comb begin
        if (head_reg > cur_reg) begin
            ring_gap = {1'b0, head_reg} - {1'b0, cur_reg} - rrss_pkg::slot_dist_t'(1);
        end else begin
            ring_gap = {1'b0, head_reg} + rrss_pkg::slot_dist_t'(rrss_pkg::SLOTS)
                     - {1'b0, cur_reg} - rrss_pkg::slot_dist_t'(1);
        end
    end

    assign run_cand = (head_reg != '0) && !is_cur &&
                      (tail_upd.state == rrss_pkg::SS_RUNNABLE);

    // Decision once the scan has seen every slot.
    assign cont_c    = tick_en_reg && cur_st_reg == rrss_pkg::SS_RUNNING &&
                       cur_sl_reg < slice_limit_reg;
    assign resched_c = tick_en_reg && !cont_c;
    assign preempt_c = resched_c && cur_st_reg == rrss_pkg::SS_RUNNING;
    assign st_after  = preempt_c ? rrss_pkg::SS_RUNNABLE : cur_st_reg;
    assign sel_c     = run_found_reg ? run_idx_reg :
                       (st_after == rrss_pkg::SS_RUNNABLE) ? cur_reg : '0;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rrss_pkg::CS_IDLE: begin
                if (s_valid) begin
                    state_next = rrss_pkg::CS_SCAN;
                end
            end
            rrss_pkg::CS_SCAN: begin
                if (cnt_last) begin
                    state_next = rrss_pkg::CS_DECIDE;
                end
            end
            rrss_pkg::CS_DECIDE: begin
                state_next = rrss_pkg::CS_COMMIT;
            end
            rrss_pkg::CS_COMMIT: begin
                if (cnt_last) begin
                    state_next = rrss_pkg::CS_DONE;
                end
            end
            rrss_pkg::CS_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = rrss_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = rrss_pkg::CS_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_ready  = 1'b0;
        phase    = rrss_pkg::PH_NONE;
        out_load = 1'b0;
        cnt_next = '0;
        case (state_reg)
            rrss_pkg::CS_IDLE: begin
                s_ready = 1'b1;
            end
            rrss_pkg::CS_SCAN: begin
                phase    = rrss_pkg::PH_SCAN;
                cnt_next = cnt_last ? '0 : cnt_reg + rrss_pkg::slot_idx_t'(1);
            end
            rrss_pkg::CS_COMMIT: begin
                phase    = rrss_pkg::PH_COMMIT;
                cnt_next = cnt_last ? '0 : cnt_reg + rrss_pkg::slot_idx_t'(1);
            end
            rrss_pkg::CS_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        tail_cmd             = rrss_pkg::CMD_IDLE;
        tail_cmd.phase       = phase;
        tail_cmd.mode        = rrss_pkg::mode_t'(item_reg.mode);
        tail_cmd.sleep_ticks = item_reg.sleep_ticks;
        tail_cmd.tick_en     = tick_en_reg;
        tail_cmd.is_cur      = is_cur;
        tail_cmd.is_target   = (32'(head_reg) == 32'(item_reg.target_slot));
        tail_cmd.is_sel      = (head_reg == sel_reg);
        tail_cmd.is_fork_dst = (head_reg == dead_idx_reg);
        tail_cmd.cont        = cont_reg;
        tail_cmd.preempt     = preempt_reg;
        tail_cmd.resched     = resched_reg;
        tail_cmd.fork_ok     = fork_ok_reg;
        tail_cmd.par_sleep   = par_sleep_reg;
        tail_cmd.par_wait    = par_wait_reg;
        tail_cmd.par_slice   = par_slice_reg;
    end

    always_comb begin
        m_valid_next = (m_valid_reg && !m_ready) || out_load;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_data_next.running_slot = rrss_pkg::to_out_slot(cur_reg);
            m_data_next.switched     = resched_reg;
            m_data_next.new_slot     = fork_ok_reg ? rrss_pkg::to_out_slot(dead_idx_reg) : '0;
            m_data_next.fork_failed  = fork_fail_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rrss_pkg::CS_IDLE;
            head_reg        <= '0;
            cnt_reg         <= '0;
            cur_reg         <= '0;
            slice_limit_reg <= rrss_pkg::SLICE_LIMIT_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                slice_limit_reg <= cfg_wr_data;
            end
            if (state_reg == rrss_pkg::CS_COMMIT && cnt_last && resched_reg) begin
                cur_reg <= sel_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_valid && s_ready) begin
            item_reg       <= s_data;
            tick_en_reg    <= tick_in;
            dead_found_reg <= 1'b0;
            run_found_reg  <= 1'b0;
        end
        if (state_reg == rrss_pkg::CS_SCAN) begin
            if (is_cur) begin
                cur_st_reg    <= tail_upd.state;
                cur_sl_reg    <= tail_upd.slice_used;
                par_sleep_reg <= head_rec.sleep_left;
                par_wait_reg  <= head_rec.wait_forever;
                par_slice_reg <= head_rec.slice_used;
            end
            if (tail_upd.state == rrss_pkg::SS_DEAD &&
                (!dead_found_reg || head_reg < dead_idx_reg)) begin
                dead_found_reg <= 1'b1;
                dead_idx_reg   <= head_reg;
            end
            if (run_cand && (!run_found_reg || ring_gap < run_dist_reg)) begin
                run_found_reg <= 1'b1;
                run_idx_reg   <= head_reg;
                run_dist_reg  <= ring_gap;
            end
        end
        if (state_reg == rrss_pkg::CS_DECIDE) begin
            cont_reg      <= cont_c;
            resched_reg   <= resched_c;
            preempt_reg   <= preempt_c;
            sel_reg       <= sel_c;
            fork_ok_reg   <= (rrss_pkg::mode_t'(item_reg.mode) == rrss_pkg::MODE_FORK) &&
                             dead_found_reg;
            fork_fail_reg <= (rrss_pkg::mode_t'(item_reg.mode) == rrss_pkg::MODE_FORK) &&
                             !dead_found_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- verif/rrss_sched_checker.sv -----
// Checker that predicts and compares every scheduler result seen on the result channel.
module rrss_sched_checker
    import rrss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_t        s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_t       m_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output int         mismatches,
    output int         outstanding
);

    slot_state_t        slot_st [SLOTS];
    logic [SLEEP_W-1:0] sleep_cnt [SLOTS];
    logic               wait_mark [SLOTS];
    logic [SLICE_W-1:0] slice_cnt [SLOTS];
    int unsigned        run_slot;
    logic [SLICE_W-1:0] slice_max;

    out_t expected_results[$];

    function automatic int unsigned ring_next(input int unsigned i);
        return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    // Counts down timed sleepers, then either extends the running slice or picks a new slot.
    // Returns 1 when a new selection was made.
    function automatic logic sched_tick();
        int unsigned cur;
        int unsigned i;
        cur = run_slot;
        for (i = ring_next(cur); i != cur; i = ring_next(i)) begin
            if (slot_st[i] == SS_BLOCKED && !wait_mark[i]) begin
                sleep_cnt[i] = sleep_cnt[i] - 1'b1;
                if (sleep_cnt[i] == '0)
                    slot_st[i] = SS_RUNNABLE;
            end
        end
        if (slot_st[cur] == SS_RUNNING && slice_cnt[cur] < slice_max) begin
            slice_cnt[cur] = slice_cnt[cur] + 1'b1;
            return 1'b0;
        end
        if (slot_st[cur] == SS_RUNNING) begin
            slot_st[cur] = SS_RUNNABLE;
            slice_cnt[cur] = '0;
        end
        // Slot 0 is only ever chosen as the idle fallback.
        i = ring_next(cur);
        while (i != cur && (i == 0 || slot_st[i] != SS_RUNNABLE))
            i = ring_next(i);
        if (slot_st[i] != SS_RUNNABLE)
            i = 0;
        run_slot = i;
        slot_st[i] = SS_RUNNING;
        slice_cnt[i] = 8'd1;
        return 1'b1;
    endfunction

    function automatic out_t sched_apply_event(input in_t ev);
        out_t        res;
        int unsigned cur;
        int unsigned child;
        logic        found;
        res = '0;
        cur = run_slot;
        case (ev.mode)
            MODE_TICK: begin
                res.switched = sched_tick();
            end
            MODE_SLEEP: begin
                if (ev.sleep_ticks != '0) begin
                    slot_st[cur] = SS_BLOCKED;
                    sleep_cnt[cur] = ev.sleep_ticks;
                    wait_mark[cur] = 1'b0;
                    res.switched = sched_tick();
                end
            end
            MODE_BLOCK: begin
                slot_st[cur] = SS_BLOCKED;
                sleep_cnt[cur] = '0;
                wait_mark[cur] = 1'b1;
                res.switched = sched_tick();
            end
            MODE_EXIT: begin
                slot_st[cur] = SS_DEAD;
                res.switched = sched_tick();
            end
            MODE_WAKE: begin
                if (ev.target_slot < SLOTS && slot_st[ev.target_slot] == SS_BLOCKED) begin
                    slot_st[ev.target_slot] = SS_RUNNABLE;
                    sleep_cnt[ev.target_slot] = '0;
                    wait_mark[ev.target_slot] = 1'b0;
                end
            end
            MODE_FORK: begin
                found = 1'b0;
                child = 0;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (slot_st[i] == SS_DEAD) begin
                        found = 1'b1;
                        child = i;
                    end
                end
                if (found) begin
                    slot_st[child] = SS_RUNNABLE;
                    slice_cnt[child] = slice_cnt[cur];
                    sleep_cnt[child] = sleep_cnt[cur];
                    wait_mark[child] = wait_mark[cur];
                    res.new_slot = OUT_SLOT_W'(child);
                end else begin
                    res.fork_failed = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.running_slot = OUT_SLOT_W'(run_slot);
        return res;
    endfunction

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_st[i] = SS_DEAD;
                sleep_cnt[i] = '0;
                wait_mark[i] = 1'b0;
                slice_cnt[i] = '0;
            end
            slot_st[0] = SS_RUNNING;
            slice_cnt[0] = 8'd1;
            run_slot = 0;
            slice_max = SLICE_LIMIT_RST;
            expected_results.delete();
        end else begin
            if (cfg_wr_en)
                slice_max = cfg_wr_data;
            if (s_valid && s_ready)
                expected_results.push_back(sched_apply_event(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with nothing expected: %p", $time, m_data);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data !== want) begin
                        if (m_data.running_slot !== want.running_slot)
                            $display("%0t: running_slot expected %0d, actual %0d",
                                     $time, want.running_slot, m_data.running_slot);
                        if (m_data.switched !== want.switched)
                            $display("%0t: switched expected %0d, actual %0d",
                                     $time, want.switched, m_data.switched);
                        if (m_data.new_slot !== want.new_slot)
                            $display("%0t: new_slot expected %0d, actual %0d",
                                     $time, want.new_slot, m_data.new_slot);
                        if (m_data.fork_failed !== want.fork_failed)
                            $display("%0t: fork_failed expected %0d, actual %0d",
                                     $time, want.fork_failed, m_data.fork_failed);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// Top of the scheduler testbench: clock, reset, event stimulus, result back-pressure and verdict.
module tb_top;
    import rrss_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 3;
    localparam int PHASE_EVENTS = 140;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_t        s_data;
    logic       m_valid;
    logic       m_ready;
    out_t       m_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    int mismatches;
    int outstanding;
    int cycles;
    bit calm;

    round_robin_sleep_scheduler_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    rrss_sched_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one; none at all during a calm phase.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic in_t sched_event(input logic [2:0] mode, input logic [15:0] ticks,
                                        input logic [3:0] target);
        in_t ev;
        ev.mode = mode;
        ev.sleep_ticks = ticks;
        ev.target_slot = target;
        return ev;
    endfunction

    function automatic in_t random_event();
        in_t ev;
        int r;
        ev.sleep_ticks = 16'($urandom());
        ev.target_slot = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 38)
            ev.mode = MODE_TICK;
        else if (r < 52)
            ev.mode = MODE_SLEEP;
        else if (r < 58)
            ev.mode = MODE_BLOCK;
        else if (r < 64)
            ev.mode = MODE_EXIT;
        else if (r < 83)
            ev.mode = MODE_WAKE;
        else if (r < 97)
            ev.mode = MODE_FORK;
        else
            ev.mode = 3'($urandom_range(6, 7));
        if (ev.mode == MODE_SLEEP) begin
            // Short sleeps let sleepers come back while the run is still going.
            r = $urandom_range(0, 9);
            if (r < 7)
                ev.sleep_ticks = 16'($urandom_range(1, 12));
            else if (r == 7)
                ev.sleep_ticks = '0;
            else if (r == 8)
                ev.sleep_ticks = 16'($urandom_range(13, 300));
        end
        return ev;
    endfunction

    // Valid is left high after acceptance so that a back-to-back transaction needs
    // no second assignment in the same step.
    task automatic send_event(input in_t ev);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= ev;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_slice_limit(input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side back-pressure.
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left == 0 && hold_left == 0) begin
                stall_left = pick_gap();
                hold_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                hold_left--;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("round_robin_sleep_scheduler_unit verification failed");
        $finish;
    end

    initial begin
        in_t         directed[$];
        logic [7:0]  limits[6];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        calm = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening with the reset slice limit: a lone idle slot, unused modes,
        // forks, a zero-length sleep, wakes of slots that are not blocked, a one-tick
        // sleep, an indefinite block and its wake, a maximal sleep, exit and refork.
        directed.push_back(sched_event(MODE_TICK, 16'h0000, 4'h0));
        directed.push_back(sched_event(3'd6, 16'hFFFF, 4'hF));
        directed.push_back(sched_event(3'd7, 16'h5555, 4'hA));
        directed.push_back(sched_event(MODE_FORK, 16'hAAAA, 4'h5));
        directed.push_back(sched_event(MODE_FORK, 16'h0000, 4'h0));
        directed.push_back(sched_event(MODE_SLEEP, 16'h0000, 4'h1));
        directed.push_back(sched_event(MODE_WAKE, 16'h0000, 4'h1));
        directed.push_back(sched_event(MODE_SLEEP, 16'h0001, 4'h0));
        directed.push_back(sched_event(MODE_BLOCK, 16'hFFFF, 4'h0));
        directed.push_back(sched_event(MODE_SLEEP, 16'hFFFF, 4'h0));
        directed.push_back(sched_event(MODE_TICK, 16'h0000, 4'h0));
        directed.push_back(sched_event(MODE_TICK, 16'h0000, 4'h0));
        directed.push_back(sched_event(MODE_WAKE, 16'h0000, 4'h1));
        directed.push_back(sched_event(MODE_WAKE, 16'h0000, 4'h2));
        directed.push_back(sched_event(MODE_WAKE, 16'hFFFF, 4'hF));
        directed.push_back(sched_event(MODE_EXIT, 16'h0000, 4'h0));
        directed.push_back(sched_event(MODE_FORK, 16'h0000, 4'h0));
        directed.push_back(sched_event(MODE_BLOCK, 16'h0000, 4'h0));
        directed.push_back(sched_event(MODE_TICK, 16'h0000, 4'h0));
        directed.push_back(sched_event(MODE_EXIT, 16'h0000, 4'h0));
        directed.push_back(sched_event(MODE_TICK, 16'h0000, 4'h0));
        foreach (directed[i])
            send_event(directed[i]);
        drain_results();

        limits[0] = 8'd1;
        limits[1] = 8'd255;
        limits[2] = 8'd0;
        limits[3] = 8'd2;
        limits[4] = 8'($urandom_range(1, 255));
        limits[5] = 8'd4;
        foreach (limits[p]) begin
            write_slice_limit(limits[p]);
            calm = (p == 3);
            repeat (PHASE_EVENTS)
                send_event(random_event());
            drain_results();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("round_robin_sleep_scheduler_unit verification clean");
        else
            $display("round_robin_sleep_scheduler_unit verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rrss_pkg.sv
design/rrss_cell.sv
design/rrss_ctrl.sv
design/round_robin_sleep_scheduler_unit.sv
verif/rrss_sched_checker.sv
verif/tb_top.sv
